// ===== hw/rtl/fdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared types and constants of the diffusion stiffness assembly block.
// ----------------------------------------------------------------------------
package fdsa_pkg;

  localparam int MAX_NODES  = 16;
  localparam int MAX_DIM    = 3;
  localparam int MAX_POINTS = 32;
  localparam int MAX_DOFS   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_DIMENSION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOFS_PER_NODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_MODE     = 3'd4;

  typedef enum logic [2:0] {
    CMD_LOAD_DERIV  = 3'd0,
    CMD_LOAD_INVJAC = 3'd1,
    CMD_LOAD_WEIGHT = 3'd2,
    CMD_LOAD_TENSOR = 3'd3,
    CMD_ASSEMBLE    = 3'd4,
    CMD_READ        = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         point_index;
    logic [3:0]         node_index;
    logic [1:0]         dim_row;
    logic [1:0]         dim_col;
    logic [6:0]         matrix_row;
    logic [6:0]         matrix_col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== hw/rtl/fem_diffusion_stiffness_assembly_top.sv =====
// ----------------------------------------------------------------------------
// fem_diffusion_stiffness_assembly_top
// Element stiffness assembly for a diffusion operator in signed Q16.16.
// ----------------------------------------------------------------------------
// Load transactions (derivative, inverse Jacobian, weight, tensor) write one
// entry of their store when in range, and each answers with a registered
// response. A read transaction splits its global row and column into node and
// degree of freedom by repeated subtraction (at most 15 steps), then reads the
// node-by-node matrix memory. An assemble transaction is run by a sequencer
// around one shared multiply-accumulate unit; every product term passes
// through a memory read, a multiply and a round/saturate/accumulate step. The
// element matrix needs no clearing pass: one valid bit per entry is cleared at
// reset and at the start of each assembly.
module fem_diffusion_stiffness_assembly_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  fdsa_pkg::in_item_t                   cmd,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output fdsa_pkg::out_item_t                  rsp,
  input  logic                                 cfg_we,
  input  logic [fdsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_KRD  = 8'b0010_0000,
    S_KOUT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // Assembly phases: gradient, tensor times gradient, dot product, weighting.
  typedef enum logic [1:0] {
    PH_G = 2'd0,
    PH_D = 2'd1,
    PH_T = 2'd2,
    PH_W = 2'd3
  } phase_t;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // Raw configuration registers.
  logic [4:0] node_count;
  logic [1:0] space_dimension;
  logic [5:0] point_count;
  logic [3:0] dofs_per_node;
  logic [1:0] tensor_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 5'd1;
      space_dimension <= 2'd1;
      point_count     <= 6'd1;
      dofs_per_node   <= 4'd1;
      tensor_mode     <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        fdsa_pkg::REG_NODE_COUNT:      node_count      <= cfg_data[4:0];
        fdsa_pkg::REG_SPACE_DIMENSION: space_dimension <= cfg_data[1:0];
        fdsa_pkg::REG_POINT_COUNT:     point_count     <= cfg_data[5:0];
        fdsa_pkg::REG_DOFS_PER_NODE:   dofs_per_node   <= cfg_data[3:0];
        fdsa_pkg::REG_TENSOR_MODE:     tensor_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective values: zero acts as one, values above the maximum are clamped.
  logic [4:0] nn;
  logic [1:0] dim;
  logic [5:0] np;
  logic [3:0] ndof;
  logic       full_tensor;
  logic       mode_identity;

  always_comb begin
    nn   = (node_count == 5'd0) ? 5'd1 :
           (node_count > 5'(fdsa_pkg::MAX_NODES)) ? 5'(fdsa_pkg::MAX_NODES) : node_count;
    dim  = (space_dimension == 2'd0) ? 2'd1 : space_dimension;
    np   = (point_count == 6'd0) ? 6'd1 :
           (point_count > 6'(fdsa_pkg::MAX_POINTS)) ? 6'(fdsa_pkg::MAX_POINTS) : point_count;
    ndof = (dofs_per_node == 4'd0) ? 4'd1 :
           (dofs_per_node > 4'(fdsa_pkg::MAX_DOFS)) ? 4'(fdsa_pkg::MAX_DOFS) : dofs_per_node;
    full_tensor   = tensor_mode[1];
    mode_identity = (tensor_mode == 2'd0);
  end

  // Sequencer registers.
  state_t     state;
  phase_t     phase;
  logic [4:0] p;
  logic [3:0] i;
  logic [3:0] j;
  logic [1:0] r;
  logic [1:0] c;
  logic signed [31:0] acc;
  logic signed [31:0] dg [0:2];
  logic signed [63:0] prod;
  logic       sat_seen;
  logic [6:0] rem_r, rem_c;
  logic [3:0] q_r, q_c;
  logic [7:0] k_raddr_q;
  logic [255:0] kvalid;
  logic signed [31:0] pend_value;
  logic [1:0] pend_status;

  // Memories and their read data.
  logic signed [31:0] dmem [0:1535];
  logic signed [31:0] jmem [0:287];
  logic signed [31:0] wmem [0:31];
  logic signed [31:0] tmem [0:287];
  logic signed [31:0] gmem [0:47];
  logic signed [31:0] kmem [0:255];
  logic signed [31:0] dn_q, ij_q, w_q, tn_q, gr_q, k_q;

  logic [10:0] d_raddr;
  logic [8:0]  j_raddr, t_raddr;
  logic [5:0]  g_raddr;
  logic [7:0]  k_raddr;
  logic        g_we, k_we;
  logic [5:0]  g_waddr;
  logic [7:0]  k_waddr;

  logic cmd_fire;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  // Load addresses and range checks.
  logic [10:0] d_waddr;
  logic [8:0]  jt_waddr;
  logic        pt_ok, nd_ok, dr_ok, dc_ok;
  logic [7:0]  lim;
  logic        read_in;

  always_comb begin
    d_waddr  = 11'(cmd.point_index) * 11'd48 + 11'(cmd.node_index) * 11'd3
             + 11'(cmd.dim_row);
    jt_waddr = 9'(cmd.point_index) * 9'd9 + 9'(cmd.dim_row) * 9'd3 + 9'(cmd.dim_col);
    pt_ok    = 6'(cmd.point_index) < np;
    nd_ok    = 5'(cmd.node_index) < nn;
    dr_ok    = cmd.dim_row < dim;
    dc_ok    = cmd.dim_col < dim;
    lim      = 8'(nn) * 8'(ndof);
    read_in  = (8'(cmd.matrix_row) < lim) && (8'(cmd.matrix_col) < lim);
  end

  // A response is loaded into the output register in this cycle.
  logic rsp_load;

  always_comb begin
    rsp_load = 1'b0;
    if (state == S_IDLE && cmd_fire)
      rsp_load = !(cmd.command == fdsa_pkg::CMD_ASSEMBLE) &&
                 !(cmd.command == fdsa_pkg::CMD_READ && read_in);
    else if (state == S_DONE)
      rsp_load = !rsp_valid || rsp_ready;
  end

  // Read addresses of the sequencer.
  always_comb begin
    d_raddr = 11'(p) * 11'd48 + 11'(i) * 11'd3 + 11'(c);
    j_raddr = 9'(p) * 9'd9 + 9'(r) * 9'd3 + 9'(c);
    t_raddr = full_tensor ? (9'(p) * 9'd9 + 9'(r) * 9'd3 + 9'(c)) : 9'(p) * 9'd9;
    case (phase)
      PH_D:    g_raddr = full_tensor ? (6'(i) * 6'd3 + 6'(c)) : (6'(i) * 6'd3 + 6'(r));
      PH_T:    g_raddr = 6'(j) * 6'd3 + 6'(r);
      default: g_raddr = 6'(j) * 6'd3 + 6'(r);
    endcase
    k_raddr = (state == S_KRD) ? {q_r, q_c} : {i, j};
    g_waddr = 6'(i) * 6'd3 + 6'(r);
    k_waddr = {i, j};
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.command == fdsa_pkg::CMD_LOAD_DERIV && pt_ok && nd_ok && dr_ok)
      dmem[d_waddr] <= cmd.value;
    dn_q <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.command == fdsa_pkg::CMD_LOAD_INVJAC && pt_ok && dr_ok && dc_ok)
      jmem[jt_waddr] <= cmd.value;
    ij_q <= jmem[j_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.command == fdsa_pkg::CMD_LOAD_WEIGHT && pt_ok)
      wmem[cmd.point_index] <= cmd.value;
    w_q <= wmem[p];
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.command == fdsa_pkg::CMD_LOAD_TENSOR && pt_ok && dr_ok && dc_ok)
      tmem[jt_waddr] <= cmd.value;
    tn_q <= tmem[t_raddr];
  end

  // The multiply-accumulate result, shared by every phase.
  logic signed [31:0] op_a, op_b, base, res;
  logic signed [63:0] rounded;
  logic signed [31:0] term;
  logic signed [32:0] sum;
  logic               sat_now;

  always_comb begin
    case (phase)
      PH_G:    begin op_a = ij_q; op_b = dn_q; end
      PH_D:    begin op_a = mode_identity ? Q_ONE : tn_q; op_b = gr_q; end
      PH_T:    begin op_a = dg[r]; op_b = gr_q; end
      default: begin op_a = acc; op_b = w_q; end
    endcase

    case (phase)
      PH_G, PH_D: base = (c == 2'd0) ? 32'sd0 : acc;
      PH_T:       base = (r == 2'd0) ? 32'sd0 : acc;
      default:    base = (p == 5'd0) ? 32'sd0 : k_q;
    endcase

    // Round half toward plus infinity, then saturate.
    rounded = (prod + 64'sd32768) >>> 16;
    sat_now = 1'b0;
    if (rounded > 64'sh0000_0000_7fff_ffff) begin
      term = 32'sh7fff_ffff;
      sat_now = 1'b1;
    end else if (rounded < -64'sh0000_0000_8000_0000) begin
      term = -32'sh8000_0000;
      sat_now = 1'b1;
    end else begin
      term = rounded[31:0];
    end
    sum = 33'(base) + 33'(term);
    if (sum[32] != sum[31]) begin
      res = sum[32] ? -32'sh8000_0000 : 32'sh7fff_ffff;
      sat_now = 1'b1;
    end else begin
      res = sum[31:0];
    end
  end

  // Control of the last step of each loop level.
  logic last_c_g, last_c_d, last_r, last_i, last_j, last_p;
  always_comb begin
    last_c_g = (c + 2'd1) >= dim;
    last_c_d = !full_tensor || ((c + 2'd1) >= dim);
    last_r   = (r + 2'd1) >= dim;
    last_i   = (5'(i) + 5'd1) >= nn;
    last_j   = (5'(j) + 5'd1) >= nn;
    last_p   = (6'(p) + 6'd1) >= np;
    g_we     = (state == S_ACC) && (phase == PH_G) && last_c_g;
    k_we     = (state == S_ACC) && (phase == PH_W);
  end

  always_ff @(posedge clk) begin
    if (g_we)
      gmem[g_waddr] <= res;
    gr_q <= gmem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (k_we)
      kmem[k_waddr] <= res;
    k_q <= kmem[k_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL)
      prod <= 64'(op_a) * 64'(op_b);
    if (state == S_ACC && phase == PH_D && last_c_d)
      dg[r] <= res;
    if (state == S_KRD)
      k_raddr_q <= k_raddr;
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_G;
      rsp_valid   <= 1'b0;
      kvalid      <= '0;
      sat_seen    <= 1'b0;
      p           <= '0;
      i           <= '0;
      j           <= '0;
      r           <= '0;
      c           <= '0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load)
        rsp_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (cmd.command)
              fdsa_pkg::CMD_LOAD_DERIV: begin
                rsp_valid      <= 1'b1;
                rsp.read_value <= '0;
                rsp.status     <= (pt_ok && nd_ok && dr_ok) ? fdsa_pkg::ST_OK
                                                            : fdsa_pkg::ST_RANGE;
              end
              fdsa_pkg::CMD_LOAD_INVJAC, fdsa_pkg::CMD_LOAD_TENSOR: begin
                rsp_valid      <= 1'b1;
                rsp.read_value <= '0;
                rsp.status     <= (pt_ok && dr_ok && dc_ok) ? fdsa_pkg::ST_OK
                                                            : fdsa_pkg::ST_RANGE;
              end
              fdsa_pkg::CMD_LOAD_WEIGHT: begin
                rsp_valid      <= 1'b1;
                rsp.read_value <= '0;
                rsp.status     <= pt_ok ? fdsa_pkg::ST_OK : fdsa_pkg::ST_RANGE;
              end
              fdsa_pkg::CMD_ASSEMBLE: begin
                kvalid   <= '0;
                sat_seen <= 1'b0;
                phase    <= PH_G;
                p        <= '0;
                i        <= '0;
                j        <= '0;
                r        <= '0;
                c        <= '0;
                state    <= S_RD;
              end
              fdsa_pkg::CMD_READ: begin
                if (read_in) begin
                  rem_r <= cmd.matrix_row;
                  rem_c <= cmd.matrix_col;
                  q_r   <= '0;
                  q_c   <= '0;
                  state <= S_DIV;
                end else begin
                  rsp_valid      <= 1'b1;
                  rsp.read_value <= '0;
                  rsp.status     <= fdsa_pkg::ST_RANGE;
                end
              end
              default: begin
                rsp_valid      <= 1'b1;
                rsp.read_value <= '0;
                rsp.status     <= fdsa_pkg::ST_RANGE;
              end
            endcase
          end
        end

        S_RD:  state <= S_MUL;
        S_MUL: state <= S_ACC;

        S_ACC: begin
          if (sat_now)
            sat_seen <= 1'b1;
          // The weighting step of the last pair of the last point ends the run.
          state <= (phase == PH_W && last_j && last_i && last_p) ? S_DONE : S_RD;
          case (phase)
            PH_G: begin
              if (!last_c_g) begin
                acc <= res;
                c   <= c + 2'd1;
              end else begin
                c <= '0;
                if (!last_r) begin
                  r <= r + 2'd1;
                end else begin
                  r <= '0;
                  if (!last_i) begin
                    i <= i + 4'd1;
                  end else begin
                    i     <= '0;
                    phase <= PH_D;
                  end
                end
              end
            end
            PH_D: begin
              if (!last_c_d) begin
                acc <= res;
                c   <= c + 2'd1;
              end else begin
                c <= '0;
                if (!last_r) begin
                  r <= r + 2'd1;
                end else begin
                  r     <= '0;
                  j     <= '0;
                  phase <= PH_T;
                end
              end
            end
            PH_T: begin
              acc <= res;
              if (!last_r) begin
                r <= r + 2'd1;
              end else begin
                r     <= '0;
                phase <= PH_W;
              end
            end
            default: begin
              kvalid[k_waddr] <= 1'b1;
              if (!last_j) begin
                j     <= j + 4'd1;
                phase <= PH_T;
              end else begin
                j <= '0;
                if (!last_i) begin
                  i     <= i + 4'd1;
                  phase <= PH_D;
                end else begin
                  i <= '0;
                  if (!last_p) begin
                    p     <= p + 5'd1;
                    phase <= PH_G;
                  end else begin
                    pend_value  <= '0;
                    pend_status <= (sat_seen || sat_now) ? fdsa_pkg::ST_SAT
                                                         : fdsa_pkg::ST_OK;
                  end
                end
              end
            end
          endcase
        end

        // Quotient and remainder of row and column by the dofs per node.
        S_DIV: begin
          if (rem_r >= 7'(ndof)) begin
            rem_r <= rem_r - 7'(ndof);
            q_r   <= q_r + 4'd1;
          end
          if (rem_c >= 7'(ndof)) begin
            rem_c <= rem_c - 7'(ndof);
            q_c   <= q_c + 4'd1;
          end
          if (rem_r < 7'(ndof) && rem_c < 7'(ndof))
            state <= S_KRD;
        end

        S_KRD: state <= S_KOUT;

        S_KOUT: begin
          pend_value  <= (rem_r == rem_c && kvalid[k_raddr_q]) ? k_q : 32'sd0;
          pend_status <= fdsa_pkg::ST_OK;
          state       <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.read_value <= pend_value;
            rsp.status     <= pend_status;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diffusion stiffness assembly testbench
// Loads element data, assembles and reads back the stiffness matrix while both
// handshakes idle at random. Every response is checked against a Q16.16
// stiffness predictor that runs on each accepted command transaction.
// ----------------------------------------------------------------------------
module testbench;

  // Commands that the block does not implement; they must answer with a
  // range status and no other effect.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Longest stretch without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    fdsa_pkg::in_item_t item;
    bit                 drain;   // hold this transaction back until no response is owed
  } pending_cmd_t;

  logic                            clk;
  logic                            rst;
  logic                            cmd_valid;
  logic                            cmd_ready;
  fdsa_pkg::in_item_t              cmd;
  logic                            rsp_valid;
  logic                            rsp_ready;
  fdsa_pkg::out_item_t             rsp;
  logic                            cfg_we;
  logic [fdsa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fdsa_pkg::CFG_DATA_W-1:0] cfg_data;

  fem_diffusion_stiffness_assembly_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Command transactions waiting to be driven, and responses still owed.
  pending_cmd_t        cmd_pending_q[$];
  fdsa_pkg::out_item_t expected_rsp_q[$];
  int                  err_cnt;
  bit                  quiet;   // when set, neither side idles

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the registers (raw bits) and the stores.
  // --------------------------------------------------------------------------
  logic [4:0] p_node_count;
  logic [1:0] p_space_dim;
  logic [5:0] p_point_count;
  logic [3:0] p_dofs;
  logic [1:0] p_tensor_mode;

  int  p_deriv  [fdsa_pkg::MAX_POINTS*fdsa_pkg::MAX_NODES*fdsa_pkg::MAX_DIM];
  int  p_invjac [fdsa_pkg::MAX_POINTS*fdsa_pkg::MAX_DIM*fdsa_pkg::MAX_DIM];
  int  p_weight [fdsa_pkg::MAX_POINTS];
  int  p_tensor [fdsa_pkg::MAX_POINTS*fdsa_pkg::MAX_DIM*fdsa_pkg::MAX_DIM];
  int  p_grad   [fdsa_pkg::MAX_NODES*fdsa_pkg::MAX_DIM];
  int  p_kmat   [fdsa_pkg::MAX_NODES*fdsa_pkg::MAX_NODES];
  bit  p_sat;

  function automatic int clamp_reg(int raw, int hi);
    if (raw < 1) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  function automatic int q_sat(longint v);
    if (v > 64'sd2147483647) begin
      p_sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      p_sat = 1'b1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic int q_add(int a, int b);
    return q_sat(longint'(a) + longint'(b));
  endfunction

  // Exact product, rounded half toward plus infinity: the arithmetic shift
  // is a floor division by 2^16.
  function automatic int q_mul(int a, int b);
    longint prod;
    prod = longint'(a) * longint'(b) + 64'sd32768;
    return q_sat(prod >>> 16);
  endfunction

  task automatic kmat_assemble(input int nn, input int dim, input int np);
    int s;
    int t;
    int dg[fdsa_pkg::MAX_DIM];
    for (int k = 0; k < fdsa_pkg::MAX_NODES*fdsa_pkg::MAX_NODES; k++) p_kmat[k] = 0;
    for (int p = 0; p < np; p++) begin
      // Physical gradients of every node at this point.
      for (int i = 0; i < nn; i++) begin
        for (int r = 0; r < dim; r++) begin
          s = 0;
          for (int c = 0; c < dim; c++)
            s = q_add(s, q_mul(p_invjac[(p*fdsa_pkg::MAX_DIM + r)*fdsa_pkg::MAX_DIM + c],
                               p_deriv[(p*fdsa_pkg::MAX_NODES + i)*fdsa_pkg::MAX_DIM + c]));
          p_grad[i*fdsa_pkg::MAX_DIM + r] = s;
        end
      end
      for (int i = 0; i < nn; i++) begin
        for (int r = 0; r < dim; r++) begin
          if (p_tensor_mode == 2'd0) begin
            dg[r] = p_grad[i*fdsa_pkg::MAX_DIM + r];
          end else if (p_tensor_mode == 2'd1) begin
            dg[r] = q_mul(p_tensor[p*fdsa_pkg::MAX_DIM*fdsa_pkg::MAX_DIM],
                          p_grad[i*fdsa_pkg::MAX_DIM + r]);
          end else begin
            s = 0;
            for (int c = 0; c < dim; c++)
              s = q_add(s, q_mul(p_tensor[(p*fdsa_pkg::MAX_DIM + r)*fdsa_pkg::MAX_DIM + c],
                                 p_grad[i*fdsa_pkg::MAX_DIM + c]));
            dg[r] = s;
          end
        end
        for (int j = 0; j < nn; j++) begin
          t = 0;
          for (int r = 0; r < dim; r++)
            t = q_add(t, q_mul(dg[r], p_grad[j*fdsa_pkg::MAX_DIM + r]));
          p_kmat[i*fdsa_pkg::MAX_NODES + j] =
            q_add(p_kmat[i*fdsa_pkg::MAX_NODES + j], q_mul(t, p_weight[p]));
        end
      end
    end
  endtask

  task automatic stiffness_predict(input fdsa_pkg::in_item_t c);
    int                  nn;
    int                  dim;
    int                  np;
    int                  dpn;
    int                  lim;
    int                  rv;
    fdsa_pkg::status_t   st;
    fdsa_pkg::out_item_t e;
    nn  = clamp_reg(int'(p_node_count), fdsa_pkg::MAX_NODES);
    dim = clamp_reg(int'(p_space_dim), fdsa_pkg::MAX_DIM);
    np  = clamp_reg(int'(p_point_count), fdsa_pkg::MAX_POINTS);
    dpn = clamp_reg(int'(p_dofs), fdsa_pkg::MAX_DOFS);
    rv  = 0;
    st  = fdsa_pkg::ST_OK;
    case (c.command)
      fdsa_pkg::CMD_LOAD_DERIV: begin
        if (c.point_index < np && c.node_index < nn && c.dim_row < dim)
          p_deriv[(c.point_index*fdsa_pkg::MAX_NODES + c.node_index)*fdsa_pkg::MAX_DIM
                  + c.dim_row] = c.value;
        else st = fdsa_pkg::ST_RANGE;
      end
      fdsa_pkg::CMD_LOAD_INVJAC: begin
        if (c.point_index < np && c.dim_row < dim && c.dim_col < dim)
          p_invjac[(c.point_index*fdsa_pkg::MAX_DIM + c.dim_row)*fdsa_pkg::MAX_DIM
                   + c.dim_col] = c.value;
        else st = fdsa_pkg::ST_RANGE;
      end
      fdsa_pkg::CMD_LOAD_WEIGHT: begin
        if (c.point_index < np) p_weight[c.point_index] = c.value;
        else st = fdsa_pkg::ST_RANGE;
      end
      fdsa_pkg::CMD_LOAD_TENSOR: begin
        if (c.point_index < np && c.dim_row < dim && c.dim_col < dim)
          p_tensor[(c.point_index*fdsa_pkg::MAX_DIM + c.dim_row)*fdsa_pkg::MAX_DIM
                   + c.dim_col] = c.value;
        else st = fdsa_pkg::ST_RANGE;
      end
      fdsa_pkg::CMD_ASSEMBLE: begin
        p_sat = 1'b0;
        kmat_assemble(nn, dim, np);
        st = p_sat ? fdsa_pkg::ST_SAT : fdsa_pkg::ST_OK;
      end
      fdsa_pkg::CMD_READ: begin
        lim = nn * dpn;
        if (c.matrix_row < lim && c.matrix_col < lim) begin
          // Only matching degrees of freedom couple.
          if (c.matrix_row % dpn == c.matrix_col % dpn)
            rv = p_kmat[(c.matrix_row / dpn)*fdsa_pkg::MAX_NODES + c.matrix_col / dpn];
        end else begin
          st = fdsa_pkg::ST_RANGE;
        end
      end
      default: st = fdsa_pkg::ST_RANGE;
    endcase
    e.read_value = rv;
    e.status     = st;
    expected_rsp_q.push_back(e);
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // --------------------------------------------------------------------------
  // Command driver. A transaction stays on the bus until accepted; the gap
  // before the next one is drawn when a transaction is put on the bus.
  // --------------------------------------------------------------------------
  int  cmd_gap;
  bit  cmd_hold;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
      cmd_gap   <= 0;
    end else begin
      cmd_hold = cmd_valid && !cmd_ready;
      if (!cmd_hold) begin
        if (cmd_gap != 0) begin
          cmd_gap   <= cmd_gap - 1;
          cmd_valid <= 1'b0;
        end else if (cmd_pending_q.size() != 0 &&
                     !(cmd_pending_q[0].drain &&
                       (expected_rsp_q.size() != 0 || cmd_valid))) begin
          cmd       <= cmd_pending_q[0].item;
          cmd_valid <= 1'b1;
          cmd_gap   <= draw_gap();
          void'(cmd_pending_q.pop_front());
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: stall for a drawn number of cycles after each transaction.
  // --------------------------------------------------------------------------
  int rsp_stall;
  int rsp_draw;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
    end else if (rsp_valid && rsp_ready) begin
      rsp_draw   = draw_gap();
      rsp_stall <= rsp_draw;
      rsp_ready <= (rsp_draw == 0);
    end else if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp_ready <= (rsp_stall == 1);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Prediction comes first so that an expectation is queued before any
  // response of the same edge is checked.
  // --------------------------------------------------------------------------
  fdsa_pkg::out_item_t exp_rsp;

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) stiffness_predict(cmd);
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response transaction with nothing expected: read_value %0d status %0d",
                 $signed(rsp.read_value), rsp.status);
          err_cnt++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp.read_value !== exp_rsp.read_value) begin
            $error("read_value: expected %0d, actual %0d",
                   $signed(exp_rsp.read_value), $signed(rsp.read_value));
            err_cnt++;
          end
          if (rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog over cycles in which neither channel moves a transaction.
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. The generator keeps the effective configuration and a record of
  // which store entries have been loaded, so that an assembly never touches an
  // entry that was never written.
  // --------------------------------------------------------------------------
  int g_nn;
  int g_dim;
  int g_np;
  int g_dpn;
  bit w_deriv  [fdsa_pkg::MAX_POINTS*fdsa_pkg::MAX_NODES*fdsa_pkg::MAX_DIM];
  bit w_invjac [fdsa_pkg::MAX_POINTS*fdsa_pkg::MAX_DIM*fdsa_pkg::MAX_DIM];
  bit w_weight [fdsa_pkg::MAX_POINTS];
  bit w_tensor [fdsa_pkg::MAX_POINTS*fdsa_pkg::MAX_DIM*fdsa_pkg::MAX_DIM];

  function automatic fdsa_pkg::in_item_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(fdsa_pkg::in_item_t)-1:0];
  endfunction

  // Mostly values near one so that sums stay meaningful, with some full-range
  // values and the two extremes to drive saturation.
  function automatic logic [31:0] rand_value(bit tame);
    int sel;
    sel = $urandom_range(0, 9);
    if (!tame && sel == 0) return $urandom;
    if (!tame && sel == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return $urandom_range(0, 32'h40000) - 32'h20000;
  endfunction

  task automatic push_cmd(input fdsa_pkg::in_item_t it, input bit drain);
    pending_cmd_t pc;
    case (it.command)
      fdsa_pkg::CMD_LOAD_DERIV:
        if (it.point_index < g_np && it.node_index < g_nn && it.dim_row < g_dim)
          w_deriv[(it.point_index*fdsa_pkg::MAX_NODES + it.node_index)*fdsa_pkg::MAX_DIM
                  + it.dim_row] = 1'b1;
      fdsa_pkg::CMD_LOAD_INVJAC:
        if (it.point_index < g_np && it.dim_row < g_dim && it.dim_col < g_dim)
          w_invjac[(it.point_index*fdsa_pkg::MAX_DIM + it.dim_row)*fdsa_pkg::MAX_DIM
                   + it.dim_col] = 1'b1;
      fdsa_pkg::CMD_LOAD_WEIGHT:
        if (it.point_index < g_np) w_weight[it.point_index] = 1'b1;
      fdsa_pkg::CMD_LOAD_TENSOR:
        if (it.point_index < g_np && it.dim_row < g_dim && it.dim_col < g_dim)
          w_tensor[(it.point_index*fdsa_pkg::MAX_DIM + it.dim_row)*fdsa_pkg::MAX_DIM
                   + it.dim_col] = 1'b1;
      default: ;
    endcase
    pc.item  = it;
    pc.drain = drain;
    cmd_pending_q.push_back(pc);
  endtask

  task automatic push_load(input logic [2:0] op, input int pt, input int nd, input int dr,
                           input int dc, input logic [31:0] val);
    fdsa_pkg::in_item_t it;
    it = random_item();
    it.command     = op;
    it.point_index = 5'(pt);
    it.node_index  = 4'(nd);
    it.dim_row     = 2'(dr);
    it.dim_col     = 2'(dc);
    it.value       = val;
    push_cmd(it, 1'b0);
  endtask

  task automatic push_read(input int r, input int c);
    fdsa_pkg::in_item_t it;
    it = random_item();
    it.command    = fdsa_pkg::CMD_READ;
    it.matrix_row = 7'(r);
    it.matrix_col = 7'(c);
    push_cmd(it, 1'b0);
  endtask

  task automatic push_op(input logic [2:0] op);
    fdsa_pkg::in_item_t it;
    it = random_item();
    it.command = op;
    push_cmd(it, 1'b0);
  endtask

  // Registers change only with the block idle and no response owed. The check
  // runs at the falling edge, after every update of the rising edge.
  task automatic write_reg(input logic [fdsa_pkg::CFG_IDX_W-1:0] idx, input int data);
    while (cmd_pending_q.size() != 0 || expected_rsp_q.size() != 0 || cmd_valid)
      @(negedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[fdsa_pkg::CFG_DATA_W-1:0];
    case (idx)
      fdsa_pkg::REG_NODE_COUNT:      p_node_count  = data[4:0];
      fdsa_pkg::REG_SPACE_DIMENSION: p_space_dim   = data[1:0];
      fdsa_pkg::REG_POINT_COUNT:     p_point_count = data[5:0];
      fdsa_pkg::REG_DOFS_PER_NODE:   p_dofs        = data[3:0];
      fdsa_pkg::REG_TENSOR_MODE:     p_tensor_mode = data[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int nn_raw, input int dim_raw, input int np_raw,
                           input int dpn_raw, input int mode_raw, input int count);
    int                 sel;
    int                 lim;
    fdsa_pkg::in_item_t it;
    write_reg(fdsa_pkg::REG_NODE_COUNT, nn_raw);
    write_reg(fdsa_pkg::REG_SPACE_DIMENSION, dim_raw);
    write_reg(fdsa_pkg::REG_POINT_COUNT, np_raw);
    write_reg(fdsa_pkg::REG_DOFS_PER_NODE, dpn_raw);
    write_reg(fdsa_pkg::REG_TENSOR_MODE, mode_raw);
    g_nn  = clamp_reg(nn_raw & 5'h1f, fdsa_pkg::MAX_NODES);
    g_dim = clamp_reg(dim_raw & 2'h3, fdsa_pkg::MAX_DIM);
    g_np  = clamp_reg(np_raw & 6'h3f, fdsa_pkg::MAX_POINTS);
    g_dpn = clamp_reg(dpn_raw & 4'hf, fdsa_pkg::MAX_DOFS);
    lim   = g_nn * g_dpn;
    quiet = ($urandom_range(0, 3) == 0);

    // Load every entry in the configured range that has never been written.
    for (int p = 0; p < g_np; p++) begin
      for (int r = 0; r < g_dim; r++) begin
        for (int n = 0; n < g_nn; n++)
          if (!w_deriv[(p*fdsa_pkg::MAX_NODES + n)*fdsa_pkg::MAX_DIM + r])
            push_load(fdsa_pkg::CMD_LOAD_DERIV, p, n, r, 0, rand_value(1'b1));
        for (int c = 0; c < g_dim; c++) begin
          if (!w_invjac[(p*fdsa_pkg::MAX_DIM + r)*fdsa_pkg::MAX_DIM + c])
            push_load(fdsa_pkg::CMD_LOAD_INVJAC, p, 0, r, c, rand_value(1'b1));
          if (!w_tensor[(p*fdsa_pkg::MAX_DIM + r)*fdsa_pkg::MAX_DIM + c])
            push_load(fdsa_pkg::CMD_LOAD_TENSOR, p, 0, r, c, rand_value(1'b1));
        end
      end
      if (!w_weight[p]) push_load(fdsa_pkg::CMD_LOAD_WEIGHT, p, 0, 0, 0, rand_value(1'b1));
    end
    push_op(fdsa_pkg::CMD_ASSEMBLE);

    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        push_load(3'($urandom_range(0, 3)), $urandom_range(0, g_np-1),
                  $urandom_range(0, g_nn-1), $urandom_range(0, g_dim-1),
                  $urandom_range(0, g_dim-1), rand_value(1'b0));
      end else if (sel < 58) begin
        // Arbitrary indices, mostly outside the configured range.
        it = random_item();
        it.command = 3'($urandom_range(0, 3));
        push_cmd(it, 1'b0);
      end else if (sel < 61) begin
        push_op($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7);
      end else if (sel < 66) begin
        push_op(fdsa_pkg::CMD_ASSEMBLE);
      end else if (sel < 70) begin
        push_read($urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        it = random_item();
        it.command    = fdsa_pkg::CMD_READ;
        it.matrix_row = 7'($urandom_range(0, lim-1));
        it.matrix_col = 7'($urandom_range(0, lim-1));
        // Now and then the sender waits for every owed response first.
        push_cmd(it, $urandom_range(0, 49) == 0);
      end
    end
    push_op(fdsa_pkg::CMD_ASSEMBLE);
    for (int k = 0; k < 4; k++) push_read($urandom_range(0, lim-1), $urandom_range(0, lim-1));
  endtask

  initial begin
    err_cnt       = 0;
    quiet         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    p_node_count  = 5'd1;
    p_space_dim   = 2'd1;
    p_point_count = 6'd1;
    p_dofs        = 4'd1;
    p_tensor_mode = 2'd0;
    g_nn  = 1;
    g_dim = 1;
    g_np  = 1;
    g_dpn = 1;
    for (int k = 0; k < fdsa_pkg::MAX_NODES*fdsa_pkg::MAX_NODES; k++) p_kmat[k] = 0;
    @(negedge rst);

    // Directed part under the reset configuration: one node, one point.
    push_read(0, 0);                                  // cleared matrix reads zero
    push_load(fdsa_pkg::CMD_LOAD_DERIV,  0, 0, 0, 0, 32'h00010000);
    push_load(fdsa_pkg::CMD_LOAD_INVJAC, 0, 0, 0, 0, 32'h00020000);
    push_load(fdsa_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 0, 32'h00008000);
    push_load(fdsa_pkg::CMD_LOAD_TENSOR, 0, 0, 0, 0, 32'hfffe0000);
    push_op(fdsa_pkg::CMD_ASSEMBLE);
    push_read(0, 0);
    push_read(127, 0);                                // read outside the matrix
    push_read(0, 127);
    push_op(CMD_SPARE_6);
    push_op(CMD_SPARE_7);
    push_load(fdsa_pkg::CMD_LOAD_DERIV,  31, 0, 0, 0, 32'h7fffffff);  // point out of range
    push_load(fdsa_pkg::CMD_LOAD_DERIV,  0, 15, 0, 0, 32'h7fffffff);  // node out of range
    push_load(fdsa_pkg::CMD_LOAD_INVJAC, 0, 0, 3, 0, 32'h80000000);   // row out of range
    push_load(fdsa_pkg::CMD_LOAD_TENSOR, 0, 0, 0, 3, 32'h80000000);   // column out of range
    push_load(fdsa_pkg::CMD_LOAD_WEIGHT, 31, 0, 0, 0, 32'h7fffffff);
    // Saturation during assembly: extreme entries make the products overflow.
    push_load(fdsa_pkg::CMD_LOAD_DERIV,  0, 0, 0, 0, 32'h7fffffff);
    push_load(fdsa_pkg::CMD_LOAD_INVJAC, 0, 0, 0, 0, 32'h80000000);
    push_load(fdsa_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 0, 32'h7fffffff);
    push_op(fdsa_pkg::CMD_ASSEMBLE);
    push_read(0, 0);

    // Extremes first: raw values of zero and above the maximum, full tensor.
    run_phase(31, 3, 2, 15, 3, 40);
    run_phase(2, 1, 63, 8, 1, 30);
    run_phase(0, 0, 0, 0, 2, 30);
    run_phase(16, 2, 1, 8, 0, 60);
    for (int ph = 0; ph < 16; ph++)
      run_phase($urandom_range(0, 5), $urandom_range(0, 3), $urandom_range(0, 4),
                $urandom_range(0, 15), $urandom_range(0, 3), 45);

    while (cmd_pending_q.size() != 0 || expected_rsp_q.size() != 0 || cmd_valid)
      @(negedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fdsa_pkg.sv
hw/rtl/fem_diffusion_stiffness_assembly_top.sv
tb/testbench.sv
